[design/sipc_pkg.sv]
// Shared types and constants for the source IP packet counter.
// No dependencies; imported by the top level of the block.
package sipc_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 64;
  localparam int unsigned ADDR_W          = 32;
  localparam int unsigned COUNT_W         = 32;
  localparam int unsigned INDEX_OUT_W     = 6;
  localparam int unsigned TDATA_OUT_W     = 104;
  localparam int unsigned TUSER_OUT_W     = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_RDCNT = 6'b000100,
    S_INC   = 6'b001000,
    S_MISS  = 6'b010000,
    S_OUT   = 6'b100000
  } sipc_state_e;

  // Result of one frame before it moves to the output register.
  typedef struct packed {
    logic                   hit;
    logic                   dropped_full;
    logic [INDEX_OUT_W-1:0] entry_index;
    logic [COUNT_W-1:0]     entry_count;
  } sipc_result_t;

endpackage

[design/sipc_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies; used for the host address and host count tables.
module sipc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/source_ip_packet_counter_unit.sv]
// Top level of the per-host IPv4 source address packet counter.
// Depends on sipc_pkg and on sipc_ram for the address and count tables.
//
// A frame is taken only in S_IDLE. The scan reads one address entry per cycle
// up to the occupancy or a hit, the compare trailing the registered read; a hit
// then passes S_RDCNT and S_INC, a new or dropped address S_MISS, and both load
// the output register from S_OUT. The input is ready again only once the
// result is registered, one frame at a time; a stalled result holds it off.
// Reset (rst_ni, asynchronous, active low) empties the table via occupancy only.
module source_ip_packet_counter_unit
  import sipc_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Input stream. tdata: [31:0] source_address.
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [ADDR_W-1:0]      s_axis_tdata_i,
  // Result stream. tdata: [5:0] entry_index, [37:6] entry_count,
  // [69:38] top_address, [101:70] top_count, [103:102] zero.
  // tuser: [0] hit, [1] dropped_full.
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [TDATA_OUT_W-1:0] m_axis_tdata_o,
  output logic [TUSER_OUT_W-1:0] m_axis_tuser_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned OCC_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [OCC_W-1:0] DEPTH_OCC = OCC_W'(TABLE_DEPTH);

  sipc_state_e state_q, state_d;

  // Occupancy and the current top talker. The leader's address is kept in a
  // register so that the result never needs a second read of the table.
  logic [OCC_W-1:0]   occ_q, occ_d;
  logic [IDX_W-1:0]   lead_idx_q, lead_idx_d;
  logic [COUNT_W-1:0] lead_cnt_q, lead_cnt_d;
  logic [ADDR_W-1:0]  lead_addr_q, lead_addr_d;

  // Scan pointer and the compare stage that trails the registered RAM read.
  logic [OCC_W-1:0]   ptr_q, ptr_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]   cmp_idx_q, cmp_idx_d;
  logic [IDX_W-1:0]   hit_idx_q, hit_idx_d;
  logic [ADDR_W-1:0]  key_q, key_d;

  sipc_result_t       res_q, res_d;

  logic                   out_vld_q, out_vld_d;
  logic [TDATA_OUT_W-1:0] out_data_q, out_data_d;
  logic [TUSER_OUT_W-1:0] out_user_q, out_user_d;

  // RAM ports.
  logic               addr_we, cnt_we;
  logic [IDX_W-1:0]   addr_ram_a, cnt_ram_a;
  logic [ADDR_W-1:0]  addr_rdata;
  logic [COUNT_W-1:0] cnt_wdata, cnt_rdata;

  logic               issue;
  logic               scan_hit;
  logic [COUNT_W-1:0] cnt_inc;
  logic [IDX_W-1:0]   promo_idx;
  logic [COUNT_W-1:0] promo_cnt;
  logic               promo_en;
  logic               promote;
  logic [IDX_W+INDEX_OUT_W-1:0] idx_ext;
  logic [ADDR_W-1:0]  top_addr;
  logic [COUNT_W-1:0] top_cnt;

  sipc_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (TABLE_DEPTH)
  ) u_addr_ram (
    .clk_i   (clk_i),
    .we_i    (addr_we),
    .addr_i  (addr_ram_a),
    .wdata_i (key_q),
    .rdata_o (addr_rdata)
  );

  sipc_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .addr_i  (cnt_ram_a),
    .wdata_i (cnt_wdata),
    .rdata_o (cnt_rdata)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);

  // An entry is read only while the pointer is below the occupancy, so no
  // unwritten RAM word ever reaches the compare.
  assign issue    = (ptr_q < occ_q);
  assign scan_hit = cmp_vld_q && (addr_rdata == key_q);
  assign cnt_inc  = (cnt_rdata == COUNT_MAX) ? cnt_rdata : cnt_rdata + COUNT_W'(1);

  // The shared leader compare: a higher count wins, and on a tie the entry
  // inserted earlier wins.
  assign promote = promo_en &&
                   ((promo_cnt > lead_cnt_q) ||
                    ((promo_cnt == lead_cnt_q) && (promo_idx < lead_idx_q)));

  assign top_addr = (lead_cnt_q != '0) ? lead_addr_q : '0;
  assign top_cnt  = lead_cnt_q;

  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    lead_idx_d  = lead_idx_q;
    lead_cnt_d  = lead_cnt_q;
    lead_addr_d = lead_addr_q;
    ptr_d       = ptr_q;
    cmp_vld_d   = cmp_vld_q;
    cmp_idx_d   = cmp_idx_q;
    hit_idx_d   = hit_idx_q;
    key_d       = key_q;
    res_d       = res_q;
    out_vld_d   = out_vld_q;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;

    addr_we    = 1'b0;
    cnt_we     = 1'b0;
    addr_ram_a = ptr_q[IDX_W-1:0];
    cnt_ram_a  = hit_idx_q;
    cnt_wdata  = cnt_inc;
    promo_en   = 1'b0;
    promo_idx  = hit_idx_q;
    promo_cnt  = cnt_inc;
    idx_ext    = '0;

    if (out_vld_q && m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          key_d     = s_axis_tdata_i;
          ptr_d     = '0;
          cmp_vld_d = 1'b0;
          state_d   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          hit_idx_d = cmp_idx_q;
          cmp_vld_d = 1'b0;
          state_d   = S_RDCNT;
        end else if (!issue && !cmp_vld_q) begin
          state_d = S_MISS;
        end else begin
          cmp_vld_d = issue;
          cmp_idx_d = ptr_q[IDX_W-1:0];
          if (issue) begin
            ptr_d = ptr_q + OCC_W'(1);
          end
        end
      end
      S_RDCNT: begin
        state_d = S_INC;
      end
      S_INC: begin
        cnt_we   = 1'b1;
        promo_en = 1'b1;
        if (promote) begin
          lead_idx_d  = hit_idx_q;
          lead_cnt_d  = cnt_inc;
          lead_addr_d = key_q;
        end
        idx_ext            = {{INDEX_OUT_W{1'b0}}, hit_idx_q};
        res_d.hit          = 1'b1;
        res_d.dropped_full = 1'b0;
        res_d.entry_index  = idx_ext[INDEX_OUT_W-1:0];
        res_d.entry_count  = cnt_inc;
        state_d            = S_OUT;
      end
      S_MISS: begin
        addr_ram_a = occ_q[IDX_W-1:0];
        cnt_ram_a  = occ_q[IDX_W-1:0];
        cnt_wdata  = COUNT_W'(1);
        promo_idx  = occ_q[IDX_W-1:0];
        promo_cnt  = COUNT_W'(1);
        res_d.hit  = 1'b0;
        if (occ_q < DEPTH_OCC) begin
          addr_we  = 1'b1;
          cnt_we   = 1'b1;
          promo_en = 1'b1;
          if (promote) begin
            lead_idx_d  = occ_q[IDX_W-1:0];
            lead_cnt_d  = COUNT_W'(1);
            lead_addr_d = key_q;
          end
          occ_d              = occ_q + OCC_W'(1);
          idx_ext            = {{INDEX_OUT_W{1'b0}}, occ_q[IDX_W-1:0]};
          res_d.dropped_full = 1'b0;
          res_d.entry_index  = idx_ext[INDEX_OUT_W-1:0];
          res_d.entry_count  = COUNT_W'(1);
        end else begin
          res_d.dropped_full = 1'b1;
          res_d.entry_index  = '0;
          res_d.entry_count  = '0;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        // Wait here until the output register is free to take the result.
        if (!out_vld_q || m_axis_tready_i) begin
          out_vld_d  = 1'b1;
          out_data_d = {2'b00, top_cnt, top_addr, res_q.entry_count, res_q.entry_index};
          out_user_d = {res_q.dropped_full, res_q.hit};
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      occ_q      <= '0;
      lead_idx_q <= '0;
      lead_cnt_q <= '0;
      cmp_vld_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      occ_q      <= occ_d;
      lead_idx_q <= lead_idx_d;
      lead_cnt_q <= lead_cnt_d;
      cmp_vld_q  <= cmp_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lead_addr_q <= lead_addr_d;
    ptr_q       <= ptr_d;
    cmp_idx_q   <= cmp_idx_d;
    hit_idx_q   <= hit_idx_d;
    key_q       <= key_d;
    res_q       <= res_d;
    out_data_q  <= out_data_d;
    out_user_q  <= out_user_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  // The table never holds more hosts than it has rows.
  assert property (@(posedge clk_i) disable iff (!rst_ni) occ_q <= DEPTH_OCC)
    else $error("occupancy exceeds table depth");

  // Occupancy grows by at most one host per cycle and never shrinks.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q == $past(occ_q)) || (occ_q == $past(occ_q) + OCC_W'(1)))
    else $error("occupancy changed by more than one");

  // A non-empty table always has a leader with a non-zero count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q != '0) |-> (lead_cnt_q != '0))
    else $error("non-empty table without a leader");

  // The leader is always a stored entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q != '0) |-> (OCC_W'(lead_idx_q) < occ_q))
    else $error("leader index beyond occupancy");

  // A hit found by the scan lies within the occupied part of the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RDCNT) |-> (OCC_W'(hit_idx_q) < occ_q))
    else $error("hit index beyond occupancy");

endmodule

[verif/source_ip_packet_counter_unit_test.sv]
// Self-checking testbench for the per-host IPv4 source address packet counter.
// Depends on sipc_pkg and on source_ip_packet_counter_unit from the design folder.
module source_ip_packet_counter_unit_test
  import sipc_pkg::*;
;

  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned RESET_CYCLES   = 5;
  localparam int unsigned RANDOM_FRAMES  = 1084;
  localparam int unsigned MAX_GAP        = 17;
  // The result sink stops accepting once, for a long stretch, after this many
  // results. The source keeps offering frames meanwhile, so the block backs up.
  localparam int unsigned PRESSURE_AT    = 300;
  localparam int unsigned PRESSURE_HOLD  = 400;
  // A frame costs at most the random idle time on each side plus a full table
  // scan. The limit below is several times that cost over the whole run.
  localparam int unsigned TIMEOUT_CYCLES = 600000;
  localparam int unsigned DRAIN_CYCLES   = TABLE_DEPTH_DEF + 10;

  // Everything one result transfer carries, split into its fields.
  typedef struct packed {
    logic                   hit;
    logic                   dropped_full;
    logic [INDEX_OUT_W-1:0] entry_index;
    logic [COUNT_W-1:0]     entry_count;
    logic [ADDR_W-1:0]      top_address;
    logic [COUNT_W-1:0]     top_count;
  } frame_result_t;

  // One row of the directed part. When has_typed is set, the result is the
  // one typed into the row; otherwise the host table model supplies it.
  typedef struct {
    logic [ADDR_W-1:0] address;
    bit                has_typed;
    frame_result_t     typed;
  } directed_row_t;

  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  // tdata: [31:0] source_address.
  logic [ADDR_W-1:0]      s_axis_tdata_i  = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  // tdata: [5:0] entry_index, [37:6] entry_count, [69:38] top_address,
  // [101:70] top_count, [103:102] zero.
  logic [TDATA_OUT_W-1:0] m_axis_tdata_o;
  // tuser: [0] hit, [1] dropped_full.
  logic [TUSER_OUT_W-1:0] m_axis_tuser_o;

  source_ip_packet_counter_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // Host table model. Entries at or above held_hosts are never read, which
  // mirrors the block: its RAMs hold garbage there after reset.
  logic [ADDR_W-1:0]  host_addr [TABLE_DEPTH_DEF];
  logic [COUNT_W-1:0] host_count [TABLE_DEPTH_DEF];
  int unsigned        held_hosts;
  int unsigned        leader_pos;
  logic [COUNT_W-1:0] leader_count;

  // Results predicted for accepted frames, oldest first.
  frame_result_t      pending_results [$];
  directed_row_t      directed_rows [$];
  logic [ADDR_W-1:0]  sent_addresses [$];

  int unsigned mismatch_count;
  int unsigned results_seen;
  int unsigned repeat_hosts;
  int unsigned new_hosts;
  int unsigned dropped_hosts;

  initial begin
    forever begin
      #(CLK_PERIOD / 2) clk_i = ~clk_i;
    end
  end

  // Fixed limit on the whole run; reaching it means the block hung.
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("Timeout after %0d cycles with %0d results outstanding", TIMEOUT_CYCLES,
             pending_results.size());
    $display("DONE: errors detected");
    $finish;
  end

  // Prints one line per mismatch and keeps the tally for the final verdict.
  task automatic report_mismatch(string what, logic [COUNT_W-1:0] got,
                                 logic [COUNT_W-1:0] wanted);
    mismatch_count++;
    $display("MISMATCH at result %0d, %s: got 0x%08h, wanted 0x%08h", results_seen, what,
             got, wanted);
  endtask

  // Applies one frame to the host table model and returns the result the
  // block must give for it. An entry that reaches the leader's count takes
  // the lead only if it was inserted earlier.
  function automatic frame_result_t count_frame(logic [ADDR_W-1:0] address);
    frame_result_t r;
    int unsigned   pos;
    bit            found;
    r     = '0;
    pos   = 0;
    found = 1'b0;
    for (int unsigned i = 0; i < held_hosts; i++) begin
      if (!found && host_addr[i] == address) begin
        found = 1'b1;
        pos   = i;
      end
    end
    if (found) begin
      if (host_count[pos] != COUNT_MAX) begin
        host_count[pos] = host_count[pos] + 1'b1;
      end
      r.hit = 1'b1;
      repeat_hosts++;
    end else if (held_hosts < TABLE_DEPTH_DEF) begin
      pos              = held_hosts;
      host_addr[pos]   = address;
      host_count[pos]  = 1;
      held_hosts++;
      new_hosts++;
    end else begin
      // Table full: nothing is stored and the leader stays as it was.
      r.dropped_full = 1'b1;
      dropped_hosts++;
    end
    if (!r.dropped_full) begin
      r.entry_index = pos[INDEX_OUT_W-1:0];
      r.entry_count = host_count[pos];
      if (host_count[pos] > leader_count ||
          (host_count[pos] == leader_count && pos < leader_pos)) begin
        leader_pos   = pos;
        leader_count = host_count[pos];
      end
    end
    if (leader_count != 0) begin
      r.top_address = host_addr[leader_pos];
      r.top_count   = leader_count;
    end
    return r;
  endfunction

  // Per-transfer wait on either side. Now and then a side switches into a
  // quiet stretch with no idling at all, so back-to-back transfers occur too.
  function automatic int unsigned draw_gap(inout bit quiet);
    if ($urandom_range(0, 29) == 0) begin
      quiet = !quiet;
    end
    return quiet ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  task automatic add_row(logic [ADDR_W-1:0] address, bit has_typed, logic hit,
                         logic dropped_full, logic [INDEX_OUT_W-1:0] entry_index,
                         logic [COUNT_W-1:0] entry_count, logic [ADDR_W-1:0] top_address,
                         logic [COUNT_W-1:0] top_count);
    directed_row_t row;
    row.address   = address;
    row.has_typed = has_typed;
    row.typed     = '{hit, dropped_full, entry_index, entry_count, top_address, top_count};
    directed_rows.push_back(row);
  endtask

  // Offers one frame on the input stream after a random idle time and waits
  // for its transfer. Inputs change only at falling edges; the handshake is
  // sampled at rising edges. When the gap is zero, tvalid simply stays high.
  // Returns the prediction of the model; the caller may replace it.
  task automatic offer_frame(input logic [ADDR_W-1:0] address, inout bit quiet,
                             output frame_result_t predicted);
    int unsigned gap;
    gap = draw_gap(quiet);
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= $urandom;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= address;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predicted = count_frame(address);
    sent_addresses.push_back(address);
  endtask

  // Result side: draws its own idle time per transfer, holds off once for a
  // long stretch, and checks every transfer against the oldest prediction.
  initial begin : result_sink
    int unsigned   gap;
    bit            quiet;
    frame_result_t got;
    frame_result_t wanted;
    quiet = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (results_seen == PRESSURE_AT) begin
        gap = PRESSURE_HOLD;
      end else begin
        gap = draw_gap(quiet);
      end
      @(negedge clk_i);
      if (gap != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
      got.hit          = m_axis_tuser_o[0];
      got.dropped_full = m_axis_tuser_o[1];
      got.entry_index  = m_axis_tdata_o[5:0];
      got.entry_count  = m_axis_tdata_o[37:6];
      got.top_address  = m_axis_tdata_o[69:38];
      got.top_count    = m_axis_tdata_o[101:70];
      if (m_axis_tdata_o[103:102] !== 2'b00) begin
        report_mismatch("tdata padding", COUNT_W'(m_axis_tdata_o[103:102]), '0);
      end
      if (pending_results.size() == 0) begin
        report_mismatch("result with no frame pending", got.entry_count, '0);
      end else begin
        wanted = pending_results.pop_front();
        if (got.hit !== wanted.hit)
          report_mismatch("hit", COUNT_W'(got.hit), COUNT_W'(wanted.hit));
        if (got.dropped_full !== wanted.dropped_full)
          report_mismatch("dropped_full", COUNT_W'(got.dropped_full),
                          COUNT_W'(wanted.dropped_full));
        if (got.entry_index !== wanted.entry_index)
          report_mismatch("entry_index", COUNT_W'(got.entry_index),
                          COUNT_W'(wanted.entry_index));
        if (got.entry_count !== wanted.entry_count)
          report_mismatch("entry_count", got.entry_count, wanted.entry_count);
        if (got.top_address !== wanted.top_address)
          report_mismatch("top_address", got.top_address, wanted.top_address);
        if (got.top_count !== wanted.top_count)
          report_mismatch("top_count", got.top_count, wanted.top_count);
      end
      results_seen++;
    end
  end

  // Main sequence: reset, directed table, random traffic, drain, verdict.
  initial begin : frame_source
    bit                quiet;
    frame_result_t     predicted;
    logic [ADDR_W-1:0] address;
    int unsigned       roll;
    int unsigned       pool;
    quiet        = 1'b0;
    held_hosts   = 0;
    leader_pos   = 0;
    leader_count = '0;

    // Extremes of the address, first insertions, and the top talker tie
    // rule. Rows whose outcome is plain are typed in; the rest are predicted.
    add_row(32'h0000_0000, 1, 0, 0, 0, 1, 32'h0000_0000, 1);
    add_row(32'hFFFF_FFFF, 1, 0, 0, 1, 1, 32'h0000_0000, 1);
    add_row(32'hFFFF_FFFF, 1, 1, 0, 1, 2, 32'hFFFF_FFFF, 2);
    // The earlier entry catches up with the leader and takes over the lead.
    add_row(32'h0000_0000, 1, 1, 0, 0, 2, 32'h0000_0000, 2);
    add_row(32'hC0A8_0001, 1, 0, 0, 2, 1, 32'h0000_0000, 2);
    add_row(32'hC0A8_0001, 0, 0, 0, 0, 0, 0, 0);
    add_row(32'hC0A8_0001, 0, 0, 0, 0, 0, 0, 0);
    add_row(32'h8000_0000, 0, 0, 0, 0, 0, 0, 0);
    add_row(32'h0000_0001, 0, 0, 0, 0, 0, 0, 0);
    add_row(32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0, 0);
    add_row(32'hFFFF_FFFE, 0, 0, 0, 0, 0, 0, 0);
    add_row(32'h0000_0000, 0, 0, 0, 0, 0, 0, 0);
    add_row(32'h0A00_0001, 0, 0, 0, 0, 0, 0, 0);
    add_row(32'h0A00_0001, 0, 0, 0, 0, 0, 0, 0);
    add_row(32'hAAAA_AAAA, 0, 0, 0, 0, 0, 0, 0);
    add_row(32'h5555_5555, 0, 0, 0, 0, 0, 0, 0);

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      offer_frame(directed_rows[i].address, quiet, predicted);
      pending_results.push_back(directed_rows[i].has_typed ? directed_rows[i].typed
                                                           : predicted);
    end

    // Random traffic. Most frames repeat known hosts, with a bias toward the
    // first few so that counts climb and the lead changes hands. Fresh
    // addresses fill the table and, once it is full, are dropped. Addresses
    // one bit away from a known host check that every compared bit matters.
    for (int unsigned n = 0; n < RANDOM_FRAMES; n++) begin
      pool = sent_addresses.size();
      roll = $urandom_range(0, 99);
      if (roll < 20) begin
        address = $urandom;
      end else if (roll < 30) begin
        address = sent_addresses[$urandom_range(0, pool - 1)] ^
                  (32'h1 << $urandom_range(0, ADDR_W - 1));
      end else if (roll < 55) begin
        address = sent_addresses[$urandom_range(0, (pool > 4) ? 3 : pool - 1)];
      end else begin
        address = sent_addresses[$urandom_range(0, pool - 1)];
      end
      offer_frame(address, quiet, predicted);
      pending_results.push_back(predicted);
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;

    // Wait for the last results, then give the block time to show any extra
    // transfer it should not make.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      report_mismatch("results never delivered", COUNT_W'(pending_results.size()), '0);
    end

    $display("Covered %0d frames: %0d repeat hosts, %0d new hosts, %0d dropped on a full table.",
             sent_addresses.size(), repeat_hosts, new_hosts, dropped_hosts);
    $display("Table ended with %0d hosts; top talker count %0d; %0d results checked.",
             held_hosts, leader_count, results_seen);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
design/sipc_pkg.sv
design/sipc_ram.sv
design/source_ip_packet_counter_unit.sv
verif/source_ip_packet_counter_unit_test.sv
